// ----- hw/rtl/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants for the 4x4 Q16.16 matrix-vector transform.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned PairW   = ProdW + 1;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned FracW   = 16;
  localparam int unsigned Dim     = 4;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegW    = 64;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam int unsigned CfgIdxW = 8;

  typedef logic signed [DataW-1:0] data_t;
  typedef data_t [Dim-1:0]         vec_t;
  typedef logic [RegW-1:0]         cfg_reg_t;
  typedef cfg_reg_t [NumRegs-1:0]  cfg_bank_t;

  localparam data_t SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam data_t SatMin = {1'b1, {(DataW-1){1'b0}}};

  // Identity matrix after reset
  localparam cfg_bank_t RegReset = '{
    64'h0001_0000_0000_0000,  // col3_rows23
    64'h0000_0000_0000_0000,  // col3_rows01
    64'h0000_0000_0001_0000,  // col2_rows23
    64'h0000_0000_0000_0000,  // col2_rows01
    64'h0000_0000_0000_0000,  // col1_rows23
    64'h0001_0000_0000_0000,  // col1_rows01
    64'h0000_0000_0000_0000,  // col0_rows23
    64'h0000_0000_0001_0000   // col0_rows01
  };

  // Per-stage advance enables, shared by all row lanes
  typedef struct packed {
    logic mul;
    logic add;
    logic sum;
    logic sat;
  } stage_en_t;

endpackage

// ----- hw/rtl/matrix_vector_transform.sv -----
// ----------------------------------------------------------------------------
// matrix_vector_transform
// 4x4 Q16.16 matrix times 4-component Q16.16 vector, saturated to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Load the matrix column-major through the configuration channel
//   (cfg_valid_i/cfg_ready_o, cfg_index_i 0..7, cfg_data_i); the even row
//   sits in the low half of each register, the odd row in the high half.
//   Writes to an index above 7 are dropped. cfg_ready_o is always high.
//   Vectors enter on in_valid_i/in_ready_o; results leave on
//   out_valid_o/out_ready_i with saturated_o set when any component clipped.
//   Each vector passes four register stages (multiply, two adder levels,
//   floor and saturate) across 16 parallel 32x32 multipliers before
//   out_valid_o rises. Throughput is one vector per cycle while the
//   receiver keeps out_ready_i high.
//   When the receiver stalls, the stages fill up in turn and bubbles are
//   squeezed out; in_ready_o drops only once all four stages hold data.
//   Reset empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
module matrix_vector_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mvt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mvt_pkg::RegW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [mvt_pkg::DataW-1:0] in_x_i,
  input  logic signed [mvt_pkg::DataW-1:0] in_y_i,
  input  logic signed [mvt_pkg::DataW-1:0] in_z_i,
  input  logic signed [mvt_pkg::DataW-1:0] in_w_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [mvt_pkg::DataW-1:0] out_x_o,
  output logic signed [mvt_pkg::DataW-1:0] out_y_o,
  output logic signed [mvt_pkg::DataW-1:0] out_z_o,
  output logic signed [mvt_pkg::DataW-1:0] out_w_o,
  output logic                         saturated_o
);
  import mvt_pkg::*;

  cfg_bank_t  cfg_q;
  stage_en_t  en;
  logic [3:0] vld_q;
  vec_t       vec;
  vec_t       coef [Dim];
  data_t      res [Dim];
  logic [Dim-1:0] clip;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= RegReset;
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      cfg_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  // A stage advances when empty or when the stage after it advances
  always_comb begin
    en.sat = ~vld_q[3] | out_ready_i;
    en.sum = ~vld_q[2] | en.sat;
    en.add = ~vld_q[1] | en.sum;
    en.mul = ~vld_q[0] | en.add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en.mul) vld_q[0] <= in_valid_i;
      if (en.add) vld_q[1] <= vld_q[0];
      if (en.sum) vld_q[2] <= vld_q[1];
      if (en.sat) vld_q[3] <= vld_q[2];
    end
  end

  assign in_ready_o = en.mul;
  assign vec = {in_w_i, in_z_i, in_y_i, in_x_i};

  for (genvar r = 0; r < Dim; r++) begin : g_row
    for (genvar j = 0; j < Dim; j++) begin : g_col
      assign coef[r][j] = cfg_q[(j << 1) | (r >> 1)][(r & 1) * DataW +: DataW];
    end
    mvt_row u_row (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (coef[r]),
      .vec_i  (vec),
      .res_o  (res[r]),
      .clip_o (clip[r])
    );
  end

  assign out_valid_o = vld_q[3];
  assign out_x_o     = res[0];
  assign out_y_o     = res[1];
  assign out_z_o     = res[2];
  assign out_w_o     = res[3];
  assign saturated_o = |clip;

  // Back-pressure reaches the input only with every stage occupied
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  a_cfg_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs))) |=> $stable(cfg_q))
    else $error("matrix changed without a valid register write");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (out_x_o == SatMax || out_x_o == SatMin || out_y_o == SatMax ||
       out_y_o == SatMin || out_z_o == SatMax || out_z_o == SatMin ||
       out_w_o == SatMax || out_w_o == SatMin))
    else $error("saturation flag without a component at a rail");

  a_out_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && !vld_q[3]) |=> out_valid_o)
    else $error("result lost between sum and output stage");

endmodule

// ----- hw/rtl/mvt_row.sv -----
// ----------------------------------------------------------------------------
// mvt_row
// One output row: four products, a two-level adder tree and floor/saturate.
// ----------------------------------------------------------------------------
module mvt_row (
  input  logic              clk_i,
  input  mvt_pkg::stage_en_t en_i,
  input  mvt_pkg::vec_t     coef_i,
  input  mvt_pkg::vec_t     vec_i,
  output mvt_pkg::data_t    res_o,
  output logic              clip_o
);
  import mvt_pkg::*;

  logic signed [ProdW-1:0] prod_q [Dim];
  logic signed [ProdW-1:0] prod_d [Dim];
  logic [PairW-1:0]        pair_lo_q, pair_hi_q, pair_lo_d, pair_hi_d;
  logic [SumW-1:0]         sum_q, sum_d;
  data_t                   res_q, res_d;
  logic                    clip_q, clip_d;
  logic                    fits;

  always_comb begin
    for (int j = 0; j < Dim; j++) begin
      prod_d[j] = $signed(coef_i[j]) * $signed(vec_i[j]);
    end
    pair_lo_d = {prod_q[0][ProdW-1], prod_q[0]} + {prod_q[1][ProdW-1], prod_q[1]};
    pair_hi_d = {prod_q[2][ProdW-1], prod_q[2]} + {prod_q[3][ProdW-1], prod_q[3]};
    sum_d     = {pair_lo_q[PairW-1], pair_lo_q} + {pair_hi_q[PairW-1], pair_hi_q};
  end

  // Floored value fits when the result's sign bit and all bits above it agree
  assign fits = (&sum_q[SumW-1:FracW+DataW-1]) | ~(|sum_q[SumW-1:FracW+DataW-1]);

  always_comb begin
    if (fits) begin
      res_d = sum_q[FracW+DataW-1:FracW];
    end else if (sum_q[SumW-1]) begin
      res_d = SatMin;
    end else begin
      res_d = SatMax;
    end
    clip_d = ~fits;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int j = 0; j < Dim; j++) begin
        prod_q[j] <= prod_d[j];
      end
    end
    if (en_i.add) begin
      pair_lo_q <= pair_lo_d;
      pair_hi_q <= pair_hi_d;
    end
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
    if (en_i.sat) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

// ----- tb/transform_checker.sv -----
// ----------------------------------------------------------------------------
// transform_checker
// Watches the configuration, vertex and result channels of the transform
// engine. It keeps its own copy of the coefficient bank and computes each
// transformed vertex exactly: 66-bit sums, floor shift, 32-bit clipping.
// Each result transaction is then compared field by field with the oldest
// expected result.
// ----------------------------------------------------------------------------
module transform_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [mvt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mvt_pkg::RegW-1:0]         cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [mvt_pkg::DataW-1:0] in_x_i,
  input  logic signed [mvt_pkg::DataW-1:0] in_y_i,
  input  logic signed [mvt_pkg::DataW-1:0] in_z_i,
  input  logic signed [mvt_pkg::DataW-1:0] in_w_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [mvt_pkg::DataW-1:0] out_x_i,
  input  logic signed [mvt_pkg::DataW-1:0] out_y_i,
  input  logic signed [mvt_pkg::DataW-1:0] out_z_i,
  input  logic signed [mvt_pkg::DataW-1:0] out_w_i,
  input  logic                             saturated_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      outstanding_o
);
  import mvt_pkg::*;

  typedef struct packed {
    vec_t comp;
    logic clip;
  } vertex_result_t;

  localparam logic signed [SumW-1:0] ClipHigh = SumW'(SatMax);
  localparam logic signed [SumW-1:0] ClipLow  = SumW'(SatMin);

  cfg_bank_t      coef_bank;
  vertex_result_t awaited_results[$];
  string          field_names[Dim] = '{"out_x", "out_y", "out_z", "out_w"};

  function automatic vertex_result_t transform_vertex(cfg_bank_t m, vec_t v);
    vertex_result_t          r;
    logic signed [SumW-1:0]  acc;
    logic signed [SumW-1:0]  floored;
    logic signed [DataW-1:0] coef;
    logic signed [DataW-1:0] comp;
    cfg_reg_t                word;
    r.clip = 1'b0;
    for (int row = 0; row < Dim; row++) begin
      acc = '0;
      for (int col = 0; col < Dim; col++) begin
        // even row in the low half, odd row in the high half
        word = m[col * 2 + row / 2];
        coef = (row % 2 == 1) ? word[RegW-1:DataW] : word[DataW-1:0];
        comp = v[col];
        acc  = acc + coef * comp;
      end
      floored = acc >>> FracW;
      if (floored > ClipHigh) begin
        r.comp[row] = SatMax;
        r.clip      = 1'b1;
      end else if (floored < ClipLow) begin
        r.comp[row] = SatMin;
        r.clip      = 1'b1;
      end else begin
        r.comp[row] = floored[DataW-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    vertex_result_t want;
    vec_t           got;
    if (!rst_ni) begin
      coef_bank    = '0;
      coef_bank[0] = 64'h0000_0000_0001_0000;
      coef_bank[2] = 64'h0001_0000_0000_0000;
      coef_bank[5] = 64'h0000_0000_0001_0000;
      coef_bank[7] = 64'h0001_0000_0000_0000;
      awaited_results.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
    end else begin
      // drop writes beyond the last register
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NumRegs) begin
        coef_bank[cfg_index_i[RegIdxW-1:0]] = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(
          transform_vertex(coef_bank, {in_w_i, in_z_i, in_y_i, in_x_i}));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no vertex outstanding");
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          got  = {out_w_i, out_z_i, out_y_i, out_x_i};
          for (int k = 0; k < Dim; k++) begin
            if (got[k] !== want.comp[k]) begin
              $error("%s: expected %0d, actual %0d", field_names[k],
                     want.comp[k], got[k]);
              mismatch_count_o++;
            end
          end
          if (saturated_i !== want.clip) begin
            $error("saturated: expected %0d, actual %0d", want.clip, saturated_i);
            mismatch_count_o++;
          end
        end
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 4x4 Q16.16 transform engine. A directed
// part covers identity, extreme, unit and single-ulp matrices, clipping at
// both ends, floor rounding of negatives and dropped out-of-range writes;
// random phases then load fresh coefficient banks and stream vertices
// with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import mvt_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned NumPhases   = 9;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned IdlePercent = 24;

  localparam data_t UnitQ     = 32'sh0001_0000;
  localparam data_t Ulp       = 32'sh0000_0001;
  localparam data_t MinusHalf = -32'sh0000_8000;
  localparam data_t PlusHalf  = 32'sh0000_8000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [RegW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  data_t               in_x_i, in_y_i, in_z_i, in_w_i;
  logic                out_valid_o;
  logic                out_ready_i;
  data_t               out_x_o, out_y_o, out_z_o, out_w_o;
  logic                saturated_o;

  logic                calm;
  int unsigned         mismatch_count;
  int unsigned         outstanding;
  int unsigned         quiet_cycles;

  matrix_vector_transform uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .in_w_i      (in_w_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o)
  );

  transform_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_x_i           (in_x_i),
    .in_y_i           (in_y_i),
    .in_z_i           (in_z_i),
    .in_w_i           (in_w_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_x_i          (out_x_o),
    .out_y_i          (out_y_o),
    .out_z_i          (out_z_o),
    .out_w_i          (out_w_o),
    .saturated_i      (saturated_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver stalls at random unless the calm stretch is on
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
  end

  // end the run once nothing has moved on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves valid high on return; the next call or drain() takes it over.
  task automatic send_vertex(input data_t x, input data_t y, input data_t z,
                             input data_t w);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_x_i     <= x;
    in_y_i     <= y;
    in_z_i     <= z;
    in_w_i     <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off the sender until every outstanding vertex has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input cfg_reg_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_bank(input cfg_bank_t bank);
    drain();
    for (int i = 0; i < NumRegs; i++) write_reg(CfgIdxW'(i), bank[i]);
  endtask

  function automatic cfg_bank_t uniform_bank(input data_t c);
    cfg_bank_t b;
    for (int i = 0; i < NumRegs; i++) b[i] = {c, c};
    return b;
  endfunction

  function automatic data_t pick_extreme();
    case ($urandom_range(4))
      0:       return SatMax;
      1:       return SatMin;
      2:       return '0;
      3:       return -Ulp;
      default: return Ulp;
    endcase
  endfunction

  function automatic data_t rand_comp();
    case ($urandom_range(9))
      0, 1, 2, 3: return data_t'($urandom);
      4, 5, 6:    return data_t'($urandom_range(0, 32'h10_0000) - 32'h8_0000);
      7:          return pick_extreme();
      8:          return data_t'($urandom) >>> $urandom_range(31);
      default:    return data_t'($urandom_range(0, 64) - 32) <<< FracW;
    endcase
  endfunction

  // style 0: full range, 1: within +-2.0, otherwise a mix with extremes
  function automatic data_t rand_coef(input int unsigned style);
    if (style == 0) return data_t'($urandom);
    if (style == 1) return data_t'($urandom_range(0, 32'h4_0000) - 32'h2_0000);
    case ($urandom_range(3))
      0:       return data_t'($urandom);
      1:       return data_t'($urandom_range(0, 32'h4_0000) - 32'h2_0000);
      2:       return pick_extreme();
      default: return ($urandom_range(1) == 1) ? UnitQ : data_t'('0);
    endcase
  endfunction

  function automatic cfg_bank_t rand_bank(input int unsigned style);
    cfg_bank_t b;
    for (int i = 0; i < NumRegs; i++) b[i] = {rand_coef(style), rand_coef(style)};
    return b;
  endfunction

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_x_i       = '0;
    in_y_i       = '0;
    in_z_i       = '0;
    in_w_i       = '0;
    calm         = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity matrix straight out of reset
    send_vertex('0, '0, '0, '0);
    send_vertex(SatMax, SatMax, SatMax, SatMax);
    send_vertex(SatMin, SatMin, SatMin, SatMin);
    send_vertex(SatMax, SatMin, Ulp, -Ulp);
    send_vertex(32'sh1234_5678, -32'sh0765_4321, UnitQ, MinusHalf);

    // largest coefficients: clip high and low
    load_bank(uniform_bank(SatMax));
    send_vertex(SatMax, SatMax, SatMax, SatMax);
    send_vertex(SatMin, SatMin, SatMin, SatMin);
    send_vertex(SatMax, SatMin, SatMax, SatMin);
    send_vertex(Ulp, '0, '0, '0);

    // most negative coefficients: products sum up to 2^64
    load_bank(uniform_bank(SatMin));
    send_vertex(SatMin, SatMin, SatMin, SatMin);
    send_vertex(SatMax, SatMax, SatMax, SatMax);
    send_vertex(SatMin, SatMax, '0, -Ulp);

    // single-ulp coefficients: floor of negative fractions
    load_bank(uniform_bank(Ulp));
    send_vertex(MinusHalf, '0, '0, '0);
    send_vertex(PlusHalf, '0, '0, '0);
    send_vertex(-Ulp, '0, '0, '0);

    // unit coefficients: right at the clipping boundaries
    load_bank(uniform_bank(UnitQ));
    send_vertex(SatMax, Ulp, '0, '0);
    send_vertex(SatMax, '0, '0, '0);
    send_vertex(SatMin, -Ulp, '0, '0);
    send_vertex(SatMin, '0, '0, '0);

    // writes beyond the last register must leave the bank alone
    drain();
    write_reg(CfgIdxW'(NumRegs), {SatMin, SatMin});
    write_reg('1, '1);
    send_vertex(UnitQ, -UnitQ, SatMax, Ulp);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      load_bank(rand_bank(p % 3));
      write_reg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, NumRegs)),
                {$urandom, $urandom});
      calm = (p == 4);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2 && p % 2 == 1) drain();
        send_vertex(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end
    calm = 1'b0;

    drain();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mvt_pkg.sv
hw/rtl/mvt_row.sv
hw/rtl/matrix_vector_transform.sv
tb/transform_checker.sv
tb/testbench.sv
